// ===== hw/rtl/effective_address_generator_top_macros.svh =====
// Assertion macros shared by the effective address generator RTL.
`ifndef EFFECTIVE_ADDRESS_GENERATOR_TOP_MACROS_SVH
`define EFFECTIVE_ADDRESS_GENERATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define EAG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be true outside reset.
`define EAG_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define EAG_ASSERT(lbl, clk, rst, prop, msg)
`define EAG_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== hw/rtl/eag_pkg.sv =====
// Types and addressing mode codes for the effective address generator.
`default_nettype none

package eag_pkg;

  // Addressing mode codes
  localparam logic [3:0] MODE_IMPL = 4'd0;
  localparam logic [3:0] MODE_IMM  = 4'd1;
  localparam logic [3:0] MODE_ZP   = 4'd2;
  localparam logic [3:0] MODE_ZPX  = 4'd3;
  localparam logic [3:0] MODE_ZPY  = 4'd4;
  localparam logic [3:0] MODE_ABS  = 4'd5;
  localparam logic [3:0] MODE_ABSX = 4'd6;
  localparam logic [3:0] MODE_ABSY = 4'd7;
  localparam logic [3:0] MODE_IND  = 4'd8;
  localparam logic [3:0] MODE_INDX = 4'd9;
  localparam logic [3:0] MODE_INDY = 4'd10;
  localparam logic [3:0] MODE_REL  = 4'd11;

  // Result action codes
  localparam logic ACT_READ = 1'b0;
  localparam logic ACT_DONE = 1'b1;

  // Input transaction kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // One result transaction
  typedef struct packed {
    logic        action;
    logic [15:0] address;
    logic [15:0] pc_out;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/eag_out_buf.sv =====
// Two-entry output register with skid slot for result transactions.
`default_nettype none
`include "effective_address_generator_top_macros.svh"

module eag_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire eag_pkg::result_t push_data,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output eag_pkg::result_t      out_data
);
  import eag_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    out_fire;
  logic    head_free;

  assign out_fire  = out_valid && out_ready;
  // Head slot can take a new result this cycle
  assign head_free = !out_valid || (out_fire && !skid_valid);
  assign room      = !skid_valid;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (head_free) begin
          out_valid <= 1'b1;
        end else if (out_fire) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push && head_free) begin
      out_data <= push_data;
    end else if (out_fire && skid_valid) begin
      out_data <= skid_data;
    end
    if (push && !head_free) begin
      skid_data <= push_data;
    end
  end

  `EAG_ASSERT_NEVER(a_skid_without_head, clk, rst, skid_valid && !out_valid, "skid full with head empty")
  `EAG_ASSERT_NEVER(a_push_when_full, clk, rst, push && skid_valid, "result pushed into full buffer")
  `EAG_ASSERT(a_skid_holds, clk, rst, (skid_valid && !out_ready) |=> skid_valid, "skid result lost")

endmodule

`default_nettype wire

// ===== hw/rtl/effective_address_generator_top.sv =====
// Effective address generator: CPU addressing mode sequencer, top level.
// Each result is registered in the output buffer before it is offered.
// Throughput: one input transaction per cycle while in_ready is high; each is resolved in
// a single registered pass through the sequencer, followed by a two-entry output buffer.
// Reset (rst, synchronous): sequencer returns to idle, held registers clear to zero,
// output buffer empties.
`default_nettype none
`include "effective_address_generator_top_macros.svh"

module effective_address_generator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [3:0]  mode,
  input  wire logic [15:0] pc_in,
  input  wire logic [7:0]  x_index,
  input  wire logic [7:0]  y_index,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             action,
  output logic [15:0]      address,
  output logic [15:0]      pc_out
);
  import eag_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_OPND1,
    PH_OPND2,
    PH_PTR_LO
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  held_mode, held_mode_next;
  logic [15:0] prog_counter, prog_counter_next;
  logic [7:0]  held_x, held_x_next;
  logic [7:0]  held_y, held_y_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [15:0] pointer, pointer_next;

  logic        in_fire;
  logic        res_valid;
  result_t     res;
  result_t     out_data;

  // Address arithmetic
  logic [7:0]  zp_x, zp_y, zp_ptr_x, ptr_lo_inc;
  logic [15:0] full_addr, full_x, full_y, rel_addr, pc_inc, pc_in_inc, ptr_inc;

  assign in_fire    = in_valid && in_ready;
  assign zp_x       = data_byte + held_x;
  assign zp_y       = data_byte + held_y;
  assign zp_ptr_x   = data_byte + held_x;
  assign ptr_lo_inc = pointer[7:0] + 8'd1;
  assign full_addr  = {data_byte, low_byte};
  assign full_x     = full_addr + {8'h00, held_x};
  assign full_y     = full_addr + {8'h00, held_y};
  assign rel_addr   = prog_counter + {{8{data_byte[7]}}, data_byte};
  assign pc_inc     = prog_counter + 16'd1;
  assign pc_in_inc  = pc_in + 16'd1;
  assign ptr_inc    = pointer + 16'd1;

  // Sequencer next state and result
  always_comb begin
    phase_next        = phase;
    held_mode_next    = held_mode;
    prog_counter_next = prog_counter;
    held_x_next       = held_x;
    held_y_next       = held_y;
    low_byte_next     = low_byte;
    pointer_next      = pointer;
    res_valid         = 1'b0;
    res               = '0;

    if (in_fire) begin
      if (kind == KIND_START) begin
        held_mode_next = mode;
        held_x_next    = x_index;
        held_y_next    = y_index;
        low_byte_next  = 8'h00;
        pointer_next   = 16'h0000;
        res_valid      = 1'b1;
        case (mode) inside
          MODE_IMM: begin
            prog_counter_next = pc_in_inc;
            phase_next        = PH_IDLE;
            res.action        = ACT_DONE;
            res.address       = pc_in;
            res.pc_out        = pc_in_inc;
          end
          MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_ABS, MODE_ABSX, MODE_ABSY,
          MODE_IND, MODE_INDX, MODE_INDY, MODE_REL: begin
            prog_counter_next = pc_in_inc;
            phase_next        = PH_OPND1;
            res.action        = ACT_READ;
            res.address       = pc_in;
          end
          default: begin
            // implied and unused modes finish at once
            prog_counter_next = pc_in;
            phase_next        = PH_IDLE;
            res.action        = ACT_DONE;
            res.address       = 16'h0000;
            res.pc_out        = pc_in;
          end
        endcase
      end else begin
        unique case (phase)
          PH_OPND1: begin
            res_valid  = 1'b1;
            res.pc_out = prog_counter;
            phase_next = PH_IDLE;
            res.action = ACT_DONE;
            case (held_mode) inside
              MODE_ZP:   res.address = {8'h00, data_byte};
              MODE_ZPX:  res.address = {8'h00, zp_x};
              MODE_ZPY:  res.address = {8'h00, zp_y};
              MODE_REL:  res.address = rel_addr;
              MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND: begin
                low_byte_next     = data_byte;
                prog_counter_next = pc_inc;
                phase_next        = PH_OPND2;
                res.action        = ACT_READ;
                res.address       = prog_counter;
                res.pc_out        = 16'h0000;
              end
              MODE_INDX: begin
                pointer_next = {8'h00, zp_ptr_x};
                phase_next   = PH_PTR_LO;
                res.action   = ACT_READ;
                res.address  = {8'h00, zp_ptr_x};
                res.pc_out   = 16'h0000;
              end
              MODE_INDY: begin
                pointer_next = {8'h00, data_byte};
                phase_next   = PH_PTR_LO;
                res.action   = ACT_READ;
                res.address  = {8'h00, data_byte};
                res.pc_out   = 16'h0000;
              end
              default: begin
                res_valid = 1'b0;
                res       = '0;
              end
            endcase
          end
          PH_OPND2: begin
            res_valid  = 1'b1;
            res.pc_out = prog_counter;
            phase_next = PH_IDLE;
            res.action = ACT_DONE;
            case (held_mode) inside
              MODE_ABS, MODE_INDX: res.address = full_addr;
              MODE_ABSX:           res.address = full_x;
              MODE_ABSY, MODE_INDY: res.address = full_y;
              MODE_IND: begin
                pointer_next = full_addr;
                phase_next   = PH_PTR_LO;
                res.action   = ACT_READ;
                res.address  = full_addr;
                res.pc_out   = 16'h0000;
              end
              default: begin
                res_valid = 1'b0;
                res       = '0;
              end
            endcase
          end
          PH_PTR_LO: begin
            phase_next = PH_IDLE;
            case (held_mode) inside
              MODE_IND: begin
                // indirect jump: pointer high byte read without page wrap
                low_byte_next  = data_byte;
                held_mode_next = MODE_INDX;
                phase_next     = PH_OPND2;
                res_valid      = 1'b1;
                res.action     = ACT_READ;
                res.address    = ptr_inc;
              end
              MODE_INDX, MODE_INDY: begin
                // zero-page pointer high byte wraps within page zero
                low_byte_next = data_byte;
                phase_next    = PH_OPND2;
                res_valid     = 1'b1;
                res.action    = ACT_READ;
                res.address   = {8'h00, ptr_lo_inc};
              end
              default: ;
            endcase
          end
          PH_IDLE: ;
          default: ;
        endcase
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      held_mode    <= MODE_IMPL;
      prog_counter <= 16'h0000;
      held_x       <= 8'h00;
      held_y       <= 8'h00;
      low_byte     <= 8'h00;
      pointer      <= 16'h0000;
    end else begin
      phase        <= phase_next;
      held_mode    <= held_mode_next;
      prog_counter <= prog_counter_next;
      held_x       <= held_x_next;
      held_y       <= held_y_next;
      low_byte     <= low_byte_next;
      pointer      <= pointer_next;
    end
  end

  // Result buffer
  eag_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign action  = out_data.action;
  assign address = out_data.address;
  assign pc_out  = out_data.pc_out;

  `EAG_ASSERT(a_idle_data_quiet, clk, rst, (in_fire && kind == KIND_DATA && phase == PH_IDLE) |-> !res_valid, "data while idle gave a result")
  `EAG_ASSERT(a_done_goes_idle, clk, rst, (res_valid && res.action == ACT_DONE) |=> phase == PH_IDLE, "sequencer busy after final address")
  `EAG_ASSERT(a_start_always_result, clk, rst, (in_fire && kind == KIND_START) |-> res_valid, "start transaction gave no result")
  `EAG_ASSERT_NEVER(a_ind_left_in_opnd2, clk, rst, phase == PH_PTR_LO && $past(phase) == PH_PTR_LO && $past(in_fire) && $past(kind) == KIND_DATA, "pointer low phase did not advance")

endmodule

`default_nettype wire

// ===== bench/effective_address_generator_top_tb.sv =====
// Testbench for the effective address generator: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module effective_address_generator_top_tb;
  import eag_pkg::*;

  // Sequencer phases of the predictor
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_OPERAND,
    PH_HIGH,
    PH_PTR_LOW
  } ea_phase_t;

  // Highest mode code; 12 and up decode as implied
  localparam logic [3:0] MODE_UNUSED_TOP = 4'hF;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [3:0]  mode;
  logic [15:0] pc_in;
  logic [7:0]  x_index;
  logic [7:0]  y_index;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic        action;
  logic [15:0] address;
  logic [15:0] pc_out;

  // Predictor copy of the sequencer state
  logic [3:0]  ea_mode;
  ea_phase_t   ea_phase;
  logic [15:0] ea_pc;
  logic [7:0]  ea_x;
  logic [7:0]  ea_y;
  logic [7:0]  ea_low;
  logic [15:0] ea_ptr;

  result_t     pending_results[$];
  int          error_count = 0;
  int          items_sent  = 0;
  int          hold_cycles = 0;
  bit          idle_on     = 1'b1;

  effective_address_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .mode      (mode),
    .pc_in     (pc_in),
    .x_index   (x_index),
    .y_index   (y_index),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action),
    .address   (address),
    .pc_out    (pc_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic result_t make_result(input logic act, input logic [15:0] addr,
                                          input logic [15:0] pc);
    result_t r;
    r.action  = act;
    r.address = addr;
    r.pc_out  = (act == ACT_DONE) ? pc : 16'h0000;
    return r;
  endfunction

  // Sequence ends: effective address out, back to idle
  function automatic result_t ea_done(input logic [15:0] addr);
    ea_phase = PH_IDLE;
    return make_result(ACT_DONE, addr, ea_pc);
  endfunction

  function automatic result_t ea_read(input logic [15:0] addr, input ea_phase_t next);
    ea_phase = next;
    return make_result(ACT_READ, addr, 16'h0000);
  endfunction

  // Operand fetch at the program counter, which then advances
  function automatic result_t ea_fetch_operand(input ea_phase_t next);
    logic [15:0] a;
    a = ea_pc;
    ea_pc = ea_pc + 16'd1;
    return ea_read(a, next);
  endfunction

  // Advance the predictor by one transaction; returns 1 when a result follows
  function automatic bit predict_address(input logic k, input logic [3:0] m,
                                         input logic [15:0] pc, input logic [7:0] x,
                                         input logic [7:0] y, input logic [7:0] b,
                                         output result_t res);
    logic [15:0] full;
    logic [15:0] imm_addr;
    bit          hit;
    res  = '0;
    hit  = 1'b1;
    full = {b, ea_low};
    if (k == KIND_START) begin
      ea_mode = m;
      ea_pc   = pc;
      ea_x    = x;
      ea_y    = y;
      ea_low  = 8'h00;
      ea_ptr  = 16'h0000;
      if (m == MODE_IMM) begin
        imm_addr = ea_pc;
        ea_pc    = ea_pc + 16'd1;
        res      = ea_done(imm_addr);
      end else if (m == MODE_IMPL || m > MODE_REL) begin
        res = ea_done(16'h0000);
      end else begin
        res = ea_fetch_operand(PH_OPERAND);
      end
      return 1'b1;
    end
    case (ea_phase)
      PH_IDLE: hit = 1'b0;
      PH_OPERAND: begin
        case (ea_mode)
          MODE_ZP:   res = ea_done({8'h00, b});
          MODE_ZPX:  res = ea_done({8'h00, b + ea_x});
          MODE_ZPY:  res = ea_done({8'h00, b + ea_y});
          MODE_REL:  res = ea_done(ea_pc + {{8{b[7]}}, b});
          MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND: begin
            ea_low = b;
            res    = ea_fetch_operand(PH_HIGH);
          end
          MODE_INDX: begin
            ea_ptr = {8'h00, b + ea_x};
            res    = ea_read(ea_ptr, PH_PTR_LOW);
          end
          MODE_INDY: begin
            ea_ptr = {8'h00, b};
            res    = ea_read(ea_ptr, PH_PTR_LOW);
          end
          default: hit = 1'b0;
        endcase
      end
      PH_HIGH: begin
        case (ea_mode)
          MODE_ABS:  res = ea_done(full);
          MODE_ABSX: res = ea_done(full + {8'h00, ea_x});
          MODE_ABSY: res = ea_done(full + {8'h00, ea_y});
          MODE_IND: begin
            ea_ptr = full;
            res    = ea_read(ea_ptr, PH_PTR_LOW);
          end
          MODE_INDX: res = ea_done(full);
          MODE_INDY: res = ea_done(full + {8'h00, ea_y});
          default:   hit = 1'b0;
        endcase
      end
      PH_PTR_LOW: begin
        if (ea_mode == MODE_IND) begin
          // jump pointer high byte: full 16-bit increment, then finish like (zp,X)
          ea_low  = b;
          ea_mode = MODE_INDX;
          res     = ea_read(ea_ptr + 16'd1, PH_HIGH);
        end else if (ea_mode == MODE_INDX || ea_mode == MODE_INDY) begin
          // zero-page pointer high byte wraps within page zero
          ea_low = b;
          res    = ea_read({8'h00, ea_ptr[7:0] + 8'd1}, PH_HIGH);
        end else begin
          hit = 1'b0;
        end
      end
      default: hit = 1'b0;
    endcase
    if (!hit) ea_phase = PH_IDLE;
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and output stalls
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result action %0d address %h pc_out %h",
                                    action, address, pc_out));
        end else begin
          want = pending_results.pop_front();
          if (action !== want.action)
            report_mismatch($sformatf("action %0d, expected %0d", action, want.action));
          if (address !== want.address)
            report_mismatch($sformatf("address %h, expected %h", address, want.address));
          if (pc_out !== want.pc_out)
            report_mismatch($sformatf("pc_out %h, expected %h", pc_out, want.pc_out));
        end
        hold_cycles = idle_on ? $urandom_range(0, 9) : 0;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
      end
      out_ready <= (hold_cycles == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return {8'hFF, pick_byte()};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [3:0] pick_mode();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(MODE_REL + 1, MODE_UNUSED_TOP));
    return 4'($urandom_range(MODE_IMPL, MODE_REL));
  endfunction

  // One input transaction; valid stays up across back-to-back transactions
  task automatic send_item(input logic k, input logic [3:0] m, input logic [15:0] pc,
                           input logic [7:0] x, input logic [7:0] y, input logic [7:0] b);
    int      gap;
    result_t res;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    mode      <= m;
    pc_in     <= pc;
    x_index   <= x;
    y_index   <= y;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (k == KIND_START || ea_phase != PH_IDLE) items_sent++;
    if (predict_address(k, m, pc, x, y, b, res)) pending_results.push_back(res);
  endtask

  task automatic send_start(input logic [3:0] m, input logic [15:0] pc,
                            input logic [7:0] x, input logic [7:0] y);
    send_item(KIND_START, m, pc, x, y, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_data(input logic [7:0] b);
    send_item(KIND_DATA, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), b);
  endtask

  // Start plus data bytes; max_bytes < 0 runs the sequence to completion
  task automatic run_sequence(input logic [3:0] m, input int max_bytes);
    int n;
    send_start(m, pick_word(), pick_byte(), pick_byte());
    n = 0;
    while (ea_phase != PH_IDLE && n != max_bytes) begin
      send_data(pick_byte());
      n++;
    end
  endtask

  // Hold off input until every expected result has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Implied, immediate with program counter wrap, and an unused mode code
  task automatic test_single_step_modes();
    send_start(MODE_IMPL, 16'h1234, 8'hFF, 8'hFF);
    send_start(MODE_IMM, 16'hFFFF, 8'h00, 8'h00);
    send_start(MODE_UNUSED_TOP, 16'hABCD, 8'h55, 8'hAA);
  endtask

  // Zero-page sums wrap at 8 bits
  task automatic test_zero_page_modes();
    send_start(MODE_ZP, 16'h0000, 8'h00, 8'h00);
    send_data(8'hFF);
    send_start(MODE_ZPX, 16'h8000, 8'hFF, 8'h00);
    send_data(8'h01);
    send_start(MODE_ZPY, 16'h7FFF, 8'h00, 8'h80);
    send_data(8'h80);
  endtask

  // Absolute fetches across the top of memory and indexed 16-bit wrap
  task automatic test_absolute_modes();
    send_start(MODE_ABS, 16'hFFFF, 8'h00, 8'h00);
    send_data(8'h34);
    send_data(8'h12);
    send_start(MODE_ABSX, 16'h1000, 8'hFF, 8'h00);
    send_data(8'hFF);
    send_data(8'hFF);
    send_start(MODE_ABSY, 16'h2000, 8'h00, 8'h01);
    send_data(8'hFF);
    send_data(8'hFF);
  endtask

  // Pointer reads: jump pointer at FFFF, zero-page pointers at FF
  task automatic test_indirect_modes();
    send_start(MODE_IND, 16'h0200, 8'h55, 8'hAA);
    send_data(8'hFF);
    send_data(8'hFF);
    send_data(8'h34);
    send_data(8'h12);
    send_start(MODE_INDX, 16'h0300, 8'h01, 8'h00);
    send_data(8'hFE);
    send_data(8'h00);
    send_data(8'h80);
    send_start(MODE_INDY, 16'h0400, 8'h00, 8'hFF);
    send_data(8'hFF);
    send_data(8'hFF);
    send_data(8'hFF);
  endtask

  // Branch offsets: negative across zero, positive
  task automatic test_relative_mode();
    send_start(MODE_REL, 16'hFFFF, 8'h00, 8'h00);
    send_data(8'h80);
    send_start(MODE_REL, 16'h1000, 8'hFF, 8'hFF);
    send_data(8'h7F);
  endtask

  // Data while idle, restart in the middle of a sequence, full drain
  task automatic test_interruptions();
    send_data(8'h5A);
    send_start(MODE_ABSX, 16'h4000, 8'h10, 8'h20);
    send_data(8'h11);
    send_start(MODE_ZP, 16'h5000, 8'h00, 8'h00);
    send_data(8'h22);
    wait_for_drain();
  endtask

  // Mostly complete sequences, some cut short, some stray data bytes
  task automatic test_random_traffic();
    int start_count;
    int pick;
    start_count = items_sent;
    while (items_sent - start_count < 1000) begin
      if ($urandom_range(0, 99) < 4) idle_on = !idle_on;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        run_sequence(pick_mode(), -1);
      end else if (pick < 92) begin
        run_sequence(pick_mode(), $urandom_range(0, 3));
      end else if (pick < 99) begin
        send_data(pick_byte());
      end else begin
        wait_for_drain();
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    kind      = KIND_START;
    mode      = MODE_IMPL;
    pc_in     = 16'h0000;
    x_index   = 8'h00;
    y_index   = 8'h00;
    data_byte = 8'h00;
    out_ready = 1'b0;
    ea_mode   = MODE_IMPL;
    ea_phase  = PH_IDLE;
    ea_pc     = 16'h0000;
    ea_x      = 8'h00;
    ea_y      = 8'h00;
    ea_low    = 8'h00;
    ea_ptr    = 16'h0000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_single_step_modes();
    test_zero_page_modes();
    test_absolute_modes();
    test_indirect_modes();
    test_relative_mode();
    test_interruptions();
    test_random_traffic();

    wait_for_drain();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
